FILE: rtl/gdr_pkg.sv
// ----------------------------------------------------------------------------
// gdr_pkg
// Types and constants shared by the grid raycaster modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdr_pkg;

  // map and screen geometry
  localparam int MAP_W     = 64;
  localparam int MAP_H     = 64;
  localparam int MAP_AW    = 12;
  localparam int MAP_DEPTH = 4096;
  localparam int SCREEN_W  = 640;
  localparam int SCREEN_H  = 480;
  localparam int HALF_H    = SCREEN_H / 2;

  // divider operand widths
  localparam int DIV_NW = 36;
  localparam int DIV_DW = 24;

  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;

  // configuration register indexes
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] CFG_PLAYER_X = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_PLAYER_Y = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_DIR_X    = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_DIR_Y    = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_PLANE_X  = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_PLANE_Y  = 3'd5;

  // divider job select
  localparam logic [2:0] DS_DX   = 3'd1;
  localparam logic [2:0] DS_DY   = 3'd2;
  localparam logic [2:0] DS_PERP = 3'd3;
  localparam logic [2:0] DS_LH   = 3'd4;

  typedef struct packed {
    logic       operation;
    logic [9:0] column;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       cell_wall;
  } gdr_in_t;

  typedef struct packed {
    logic [9:0] column_out;
    logic [8:0] strip_top;
    logic [8:0] strip_bottom;
    logic       hit_side;
    logic [1:0] face;
    logic [5:0] tex_column;
    logic       out_of_map;
  } gdr_out_t;

  typedef struct packed {
    logic        [13:0] player_x;
    logic        [13:0] player_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
  } gdr_cam_t;

  typedef struct packed {
    logic       clr_en;
    logic       map_wr;
    logic       load_col;
    logic       div_start;
    logic [2:0] div_sel;
    logic       ray_mul;
    logic       ray_add;
    logic       side_init;
    logic       walk_step;
    logic       hit_mul;
    logic       out_load;
  } gdr_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic walk_end;
  } gdr_sts_t;

endpackage

FILE: rtl/gdr_div.sv
// ----------------------------------------------------------------------------
// gdr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdr_div import gdr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num_in,
  input  logic [DIV_DW-1:0] den_in,
  output logic              done,
  output logic [DIV_NW-1:0] quot
);

  logic [DIV_NW-1:0] q_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [5:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   sh;
  logic [DIV_DW:0]   diff;
  logic              ge;

  // trial subtract
  always_comb begin
    sh   = {rem_r, q_r[DIV_NW-1]};
    ge   = sh >= {1'b0, den_r};
    diff = sh - {1'b0, den_r};
  end

  // sequence the iterations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift quotient and remainder
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num_in;
      rem_r <= '0;
      den_r <= den_in;
    end else if (busy_r) begin
      q_r   <= {q_r[DIV_NW-2:0], ge};
      rem_r <= ge ? diff[DIV_DW-1:0] : sh[DIV_DW-1:0];
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: rtl/gdr_ctrl.sv
// ----------------------------------------------------------------------------
// gdr_ctrl
// Controller: sequences map clearing, writes and the per-column cast.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdr_ctrl import gdr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_op,
  input  logic     out_free,
  input  gdr_sts_t sts,
  output logic     in_stall,
  output gdr_cmd_t cmd
);

  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_RAY_MUL = 5'd4;
  localparam logic [4:0] S_RAY_ADD = 5'd5;
  localparam logic [4:0] S_DX_GO   = 5'd6;
  localparam logic [4:0] S_DX_W    = 5'd7;
  localparam logic [4:0] S_DY_GO   = 5'd8;
  localparam logic [4:0] S_DY_W    = 5'd9;
  localparam logic [4:0] S_SIDE    = 5'd10;
  localparam logic [4:0] S_STEP    = 5'd11;
  localparam logic [4:0] S_CHECK   = 5'd12;
  localparam logic [4:0] S_PERP_GO = 5'd13;
  localparam logic [4:0] S_PERP_W  = 5'd14;
  localparam logic [4:0] S_LH_GO   = 5'd15;
  localparam logic [4:0] S_LH_W    = 5'd16;
  localparam logic [4:0] S_HIT     = 5'd17;
  localparam logic [4:0] S_FIN     = 5'd18;

  logic [4:0] state_r;
  logic [4:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_op) begin
            cmd.map_wr = 1'b1;
          end else begin
            cmd.load_col = 1'b1;
            state_nxt    = S_RAY_MUL;
          end
        end
      end
      S_RAY_MUL: begin
        cmd.ray_mul = 1'b1;
        state_nxt   = S_RAY_ADD;
      end
      S_RAY_ADD: begin
        cmd.ray_add = 1'b1;
        state_nxt   = S_DX_GO;
      end
      S_DX_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_DX;
        state_nxt     = S_DX_W;
      end
      S_DX_W: begin
        cmd.div_sel = DS_DX;
        if (sts.div_done) state_nxt = S_DY_GO;
      end
      S_DY_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_DY;
        state_nxt     = S_DY_W;
      end
      S_DY_W: begin
        cmd.div_sel = DS_DY;
        if (sts.div_done) state_nxt = S_SIDE;
      end
      S_SIDE: begin
        cmd.side_init = 1'b1;
        state_nxt     = S_STEP;
      end
      S_STEP: begin
        cmd.walk_step = 1'b1;
        state_nxt     = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = sts.walk_end ? S_PERP_GO : S_STEP;
      end
      S_PERP_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_PERP;
        state_nxt     = S_PERP_W;
      end
      S_PERP_W: begin
        cmd.div_sel = DS_PERP;
        if (sts.div_done) state_nxt = S_LH_GO;
      end
      S_LH_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_LH;
        state_nxt     = S_LH_W;
      end
      S_LH_W: begin
        cmd.div_sel = DS_LH;
        if (sts.div_done) state_nxt = S_HIT;
      end
      S_HIT: begin
        cmd.hit_mul = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/gdr_dpath.sv
// ----------------------------------------------------------------------------
// gdr_dpath
// Datapath: wall map memory, ray set-up, DDA walk and strip arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdr_dpath import gdr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  gdr_cmd_t cmd,
  input  gdr_in_t  in_data,
  input  gdr_cam_t cam,
  output gdr_sts_t sts,
  output gdr_out_t res
);

  // wall map
  logic             mem [MAP_DEPTH];
  logic             rd_r;
  logic [MAP_AW-1:0] clr_cnt_r;
  logic             wr_en;
  logic [MAP_AW-1:0] wr_addr;
  logic             wr_bit;
  logic [MAP_AW-1:0] rd_addr;

  // cast registers
  logic [9:0]         col_r;
  logic signed [17:0] cam_r;
  logic signed [33:0] pxc_r;
  logic signed [33:0] pyc_r;
  logic signed [17:0] rx_r;
  logic signed [17:0] ry_r;
  logic [23:0]        dx_r;
  logic [23:0]        dy_r;
  logic [33:0]        sx_r;
  logic [33:0]        sy_r;
  logic signed [7:0]  mx_r;
  logic signed [7:0]  my_r;
  logic               side_r;
  logic               outside_r;
  logic [23:0]        perp_r;
  logic [DIV_NW-1:0]  lh_r;
  logic [27:0]        hp_r;

  // combinational helpers
  logic [17:0]        col_x205;
  logic [7:0]         col_q;
  logic [9:0]         col_q5;
  logic [2:0]         col_rem;
  logic [7:0]         rem_part;
  logic signed [17:0] cam_nxt;
  logic [16:0]        arx;
  logic [16:0]        ary;
  logic signed [17:0] nrx;
  logic signed [17:0] nry;
  logic [8:0]         fx;
  logic [8:0]         fy;
  logic [32:0]        ix_prod;
  logic [32:0]        iy_prod;
  logic               take_x;
  logic signed [7:0]  nmx;
  logic signed [7:0]  nmy;
  logic               outside_nxt;
  logic signed [17:0] pnum;
  logic signed [17:0] pnum_neg;
  logic [14:0]        pmag;
  logic [DIV_NW-1:0]  div_num;
  logic [DIV_DW-1:0]  div_den;
  logic               div_done;
  logic [DIV_NW-1:0]  quot;
  logic signed [42:0] hit_prod;
  logic [27:0]        frac;
  logic [5:0]         tex;
  logic [34:0]        half;
  logic               big;
  logic               rx_pos;
  logic               ry_pos;

  function automatic logic [23:0] sat_dist(input logic [DIV_NW-1:0] q);
    sat_dist = (q > {12'b0, DIST_MAX}) ? DIST_MAX : q[23:0];
  endfunction

  // camera value: column * 256 / 5 by reciprocal multiply, exact for 10 bits
  always_comb begin
    col_x205 = in_data.column * 8'd205;
    col_q    = col_x205[17:10];
    col_q5   = {col_q, 2'b00} + {2'b00, col_q};
    col_rem  = 3'(in_data.column - col_q5);
    case (col_rem)
      3'd1:    rem_part = 8'd51;
      3'd2:    rem_part = 8'd102;
      3'd3:    rem_part = 8'd153;
      3'd4:    rem_part = 8'd204;
      default: rem_part = 8'd0;
    endcase
    cam_nxt = $signed({2'b00, col_q, rem_part}) - 18'sd16384;
  end

  // ray magnitudes and signs
  always_comb begin
    nrx    = -rx_r;
    nry    = -ry_r;
    arx    = rx_r[17] ? nrx[16:0] : rx_r[16:0];
    ary    = ry_r[17] ? nry[16:0] : ry_r[16:0];
    rx_pos = !rx_r[17] && (rx_r != 18'sd0);
    ry_pos = !ry_r[17] && (ry_r != 18'sd0);
  end

  // map write and clear sweep
  always_comb begin
    wr_en   = cmd.clr_en || (cmd.map_wr && (in_data.cell_x < MAP_W) && (in_data.cell_y < MAP_H));
    wr_addr = cmd.clr_en ? clr_cnt_r : {in_data.cell_y, in_data.cell_x};
    wr_bit  = cmd.clr_en ? 1'b0 : in_data.cell_wall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // DDA step: pick the axis, find the next cell
  always_comb begin
    take_x      = sx_r < sy_r;
    nmx         = mx_r;
    nmy         = my_r;
    if (take_x) begin
      nmx = rx_r[17] ? mx_r - 8'sd1 : mx_r + 8'sd1;
    end else begin
      nmy = ry_r[17] ? my_r - 8'sd1 : my_r + 8'sd1;
    end
    outside_nxt = (nmx < 8'sd0) || (nmy < 8'sd0) || (nmx >= 8'sd64) || (nmy >= 8'sd64);
    rd_addr     = {nmy[5:0], nmx[5:0]};
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_bit;
    rd_r <= mem[rd_addr];
  end

  // first side distances
  always_comb begin
    fx      = rx_r[17] ? {1'b0, cam.player_x[7:0]} : 9'd256 - {1'b0, cam.player_x[7:0]};
    fy      = ry_r[17] ? {1'b0, cam.player_y[7:0]} : 9'd256 - {1'b0, cam.player_y[7:0]};
    ix_prod = fx * dx_r;
    iy_prod = fy * dy_r;
  end

  // distance from viewer to the crossed edge
  always_comb begin
    if (!side_r) begin
      pnum = $signed({{2{mx_r[7]}}, mx_r, 8'b0}) - $signed({4'b0, cam.player_x})
             + (rx_r[17] ? 18'sd256 : 18'sd0);
    end else begin
      pnum = $signed({{2{my_r[7]}}, my_r, 8'b0}) - $signed({4'b0, cam.player_y})
             + (ry_r[17] ? 18'sd256 : 18'sd0);
    end
    pnum_neg = -pnum;
    pmag     = pnum[17] ? pnum_neg[14:0] : pnum[14:0];
  end

  // divider operands
  always_comb begin
    unique case (cmd.div_sel)
      DS_DX: begin
        div_num = 36'h010000000;
        div_den = {7'b0, arx};
      end
      DS_DY: begin
        div_num = 36'h010000000;
        div_den = {7'b0, ary};
      end
      DS_PERP: begin
        div_num = {1'b0, pmag, 20'b0};
        div_den = {7'b0, side_r ? ary : arx};
      end
      DS_LH: begin
        div_num = 36'(SCREEN_H * 16384);
        div_den = perp_r;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  gdr_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .num_in (div_num),
    .den_in (div_den),
    .done   (div_done),
    .quot   (quot)
  );

  // hit point product
  assign hit_prod = $signed({1'b0, perp_r}) * (side_r ? rx_r : ry_r);

  // cast pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.load_col) begin
      col_r <= in_data.column;
      cam_r <= cam_nxt;
    end
    if (div_done) begin
      unique case (cmd.div_sel)
        DS_DX:   dx_r   <= sat_dist(quot);
        DS_DY:   dy_r   <= sat_dist(quot);
        DS_PERP: perp_r <= sat_dist(quot);
        DS_LH:   lh_r   <= quot;
        default: ;
      endcase
    end
    if (cmd.ray_mul) begin
      pxc_r <= cam.plane_x * cam_r;
      pyc_r <= cam.plane_y * cam_r;
    end
    if (cmd.ray_add) begin
      rx_r <= {{2{cam.dir_x[15]}}, cam.dir_x} + pxc_r[31:14];
      ry_r <= {{2{cam.dir_y[15]}}, cam.dir_y} + pyc_r[31:14];
    end
    if (cmd.side_init) begin
      sx_r      <= {9'b0, ix_prod[32:8]};
      sy_r      <= {9'b0, iy_prod[32:8]};
      mx_r      <= {2'b0, cam.player_x[13:8]};
      my_r      <= {2'b0, cam.player_y[13:8]};
      side_r    <= 1'b1;
      outside_r <= 1'b0;
    end
    if (cmd.walk_step) begin
      if (take_x) sx_r <= sx_r + {10'b0, dx_r};
      else        sy_r <= sy_r + {10'b0, dy_r};
      mx_r      <= nmx;
      my_r      <= nmy;
      side_r    <= !take_x;
      outside_r <= outside_nxt;
    end
    if (cmd.hit_mul) hp_r <= hit_prod[27:0];
  end

  // strip rows, texture column and face
  always_comb begin
    frac = {(side_r ? cam.player_x[7:0] : cam.player_y[7:0]), 20'b0} + hp_r;
    tex  = frac[27:22];
    if ((!side_r && rx_pos) || (side_r && ry_r[17])) tex = ~tex;
    half = lh_r[DIV_NW-1:1];
    big  = half >= 35'(HALF_H);
    res.column_out   = col_r;
    res.strip_top    = big ? 9'd0 : 9'(HALF_H) - {1'b0, half[7:0]};
    res.strip_bottom = big ? 9'(SCREEN_H - 1) : 9'(HALF_H) + {1'b0, half[7:0]};
    res.hit_side     = side_r;
    res.face         = side_r ? (ry_pos ? 2'd2 : 2'd3) : (rx_pos ? 2'd0 : 2'd1);
    res.tex_column   = tex;
    res.out_of_map   = outside_r;
  end

  // status to the controller
  always_comb begin
    sts.clr_last = cmd.clr_en && (clr_cnt_r == MAP_AW'(MAP_DEPTH - 1));
    sts.div_done = div_done;
    sts.walk_end = outside_r || rd_r;
  end

endmodule

FILE: rtl/grid_dda_raycast_column.sv
// ----------------------------------------------------------------------------
// grid_dda_raycast_column
// Grid DDA raycaster producing one wall strip per cast transaction.
// ----------------------------------------------------------------------------
// After reset the block clears its 4096-cell wall map, one cell a cycle, and
// stalls input until the clear is done. A map write is done as it is accepted.
// For a cast transaction, the camera value comes from a reciprocal multiply
// at acceptance, four divisions (both step distances, perpendicular distance,
// line height) run on one shared 36-bit divider at one quotient bit a cycle,
// and the DDA walk reads the map once per step through a registered port.
// One cast is worked at a time; the finished strip waits in an output register
// while the next transaction is taken.
`timescale 1ns / 1ps

module grid_dda_raycast_column import gdr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gdr_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gdr_out_t          out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [15:0]       cfg_data
);

  gdr_cam_t cam_r;
  gdr_cmd_t cmd;
  gdr_sts_t sts;
  gdr_out_t res;
  gdr_out_t out_data_r;
  logic     out_valid_r;
  logic     out_free;

  // camera registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r.player_x <= 14'd384;
      cam_r.player_y <= 14'd384;
      cam_r.dir_x    <= 16'sd16384;
      cam_r.dir_y    <= 16'sd0;
      cam_r.plane_x  <= 16'sd0;
      cam_r.plane_y  <= 16'sd10813;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PLAYER_X: cam_r.player_x <= cfg_data[13:0];
        CFG_PLAYER_Y: cam_r.player_y <= cfg_data[13:0];
        CFG_DIR_X:    cam_r.dir_x    <= cfg_data;
        CFG_DIR_Y:    cam_r.dir_y    <= cfg_data;
        CFG_PLANE_X:  cam_r.plane_x  <= cfg_data;
        CFG_PLANE_Y:  cam_r.plane_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  gdr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .out_free (out_free),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  gdr_dpath u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_data (in_data),
    .cam     (cam_r),
    .sts     (sts),
    .res     (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // never overwrite a strip that has not been taken
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("strip loaded over a pending result");

  // map writes only on an accepted transaction
  a_wr_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.map_wr |-> (in_valid && !in_stall && in_data.operation))
    else $error("map write without accepted transaction");

  // a new result only follows a load
  a_rise_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.out_load))
    else $error("result appeared without load");

endmodule

FILE: test/grid_dda_raycast_column_test.sv
// ----------------------------------------------------------------------------
// grid_dda_raycast_column_test
// Self-checking bench for the grid DDA raycaster. A queue of map writes and
// column casts is driven in bursts under several camera settings; a clocked
// predictor follows the wall map and the camera registers and works out each
// wall strip, which is compared field by field with the block's output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_dda_raycast_column_test;
  import gdr_pkg::*;

  localparam logic OP_CAST  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  gdr_in_t           in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  gdr_out_t          out_data;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_index = CFG_PLAYER_X;
  logic [15:0]       cfg_data = '0;

  grid_dda_raycast_column uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gdr_in_t  pending_items[$];
  gdr_out_t strip_q[$];
  gdr_cam_t cam_regs;
  bit       wall_bits[MAP_DEPTH];
  int       errors = 0;
  int       strips_seen = 0;
  bit       in_taken = 1'b0;

  // saturated reciprocal of a ray component, Q10.14
  function automatic longint step_len(input longint r);
    longint a, d;
    a = (r < 0) ? -r : r;
    if (a == 0) return longint'(DIST_MAX);
    d = (longint'(1) << 28) / a;
    return (d > longint'(DIST_MAX)) ? longint'(DIST_MAX) : d;
  endfunction

  // predict the wall strip for one column from the current map and camera
  function automatic gdr_out_t cast_strip(input logic [9:0] col);
    longint   c, cam, px, py, rx, ry, dx, dy, sx, sy, mx, my, stx, sty, fx, fy;
    longint   num, den, perp, lh, ds, de, tex;
    longint unsigned hitpos;
    int       side;
    bit       outside, hit;
    gdr_out_t r;
    c = col;
    px = cam_regs.player_x;
    py = cam_regs.player_y;
    cam = (c * 2 * 16384) / SCREEN_W - 16384;
    rx = longint'($signed(cam_regs.dir_x)) + ((longint'($signed(cam_regs.plane_x)) * cam) >>> 14);
    ry = longint'($signed(cam_regs.dir_y)) + ((longint'($signed(cam_regs.plane_y)) * cam) >>> 14);
    dx = step_len(rx);
    dy = step_len(ry);
    mx = px >> 8;
    my = py >> 8;
    stx = (rx < 0) ? -1 : 1;
    sty = (ry < 0) ? -1 : 1;
    fx = (stx < 0) ? (px & 255) : 256 - (px & 255);
    fy = (sty < 0) ? (py & 255) : 256 - (py & 255);
    sx = (fx * dx) >> 8;
    sy = (fy * dy) >> 8;
    side = 1;
    outside = 1'b0;
    hit = 1'b0;
    // walk the grid; a tie takes the y step, leaving the grid ends the walk
    while (!hit) begin
      if (sx < sy) begin
        sx += dx; mx += stx; side = 0;
      end else begin
        sy += dy; my += sty; side = 1;
      end
      if (mx < 0 || my < 0 || mx >= MAP_W || my >= MAP_H) begin
        outside = 1'b1;
        hit = 1'b1;
      end else begin
        hit = wall_bits[my * MAP_W + mx];
      end
    end
    if (side == 0) begin
      num = mx * 256 - px + ((stx < 0) ? 256 : 0);
      den = rx;
    end else begin
      num = my * 256 - py + ((sty < 0) ? 256 : 0);
      den = ry;
    end
    if (den == 0) begin
      perp = longint'(DIST_MAX);
    end else begin
      if (num < 0) num = -num;
      if (den < 0) den = -den;
      perp = (num << 20) / den;
      if (perp > longint'(DIST_MAX)) perp = longint'(DIST_MAX);
    end
    // strip rows; viewer on the hit edge covers the whole column
    if (perp == 0) begin
      ds = 0;
      de = SCREEN_H - 1;
    end else begin
      lh = (longint'(SCREEN_H) * 16384) / perp;
      ds = SCREEN_H / 2 - lh / 2;
      de = lh / 2 + SCREEN_H / 2;
      if (ds < 0) ds = 0;
      if (de >= SCREEN_H) de = SCREEN_H - 1;
    end
    if (side == 0) hitpos = (px * 0 + (py << 20)) + perp * ry;
    else           hitpos = (px << 20) + perp * rx;
    tex = longint'((hitpos & 64'h0FFF_FFFF) >> 22);
    if ((side == 0 && rx > 0) || (side == 1 && ry < 0)) tex = 63 - tex;
    r.column_out   = col;
    r.strip_top    = ds[8:0];
    r.strip_bottom = de[8:0];
    r.hit_side     = side[0];
    r.face         = (side == 0) ? ((rx > 0) ? 2'd0 : 2'd1) : ((ry > 0) ? 2'd2 : 2'd3);
    r.tex_column   = tex[5:0];
    r.out_of_map   = outside;
    return r;
  endfunction

  // track camera writes, predict accepted transactions, check strips
  always @(posedge clk) begin
    gdr_out_t want;
    in_taken = rst_n && in_valid && !in_stall;
    if (rst_n && cfg_we) begin
      case (cfg_index)
        CFG_PLAYER_X: cam_regs.player_x = cfg_data[13:0];
        CFG_PLAYER_Y: cam_regs.player_y = cfg_data[13:0];
        CFG_DIR_X:    cam_regs.dir_x    = cfg_data;
        CFG_DIR_Y:    cam_regs.dir_y    = cfg_data;
        CFG_PLANE_X:  cam_regs.plane_x  = cfg_data;
        CFG_PLANE_Y:  cam_regs.plane_y  = cfg_data;
        default: ;
      endcase
    end
    if (in_taken) begin
      if (in_data.operation == OP_WRITE)
        wall_bits[in_data.cell_y * MAP_W + in_data.cell_x] = in_data.cell_wall;
      else
        strip_q.push_back(cast_strip(in_data.column));
    end
    if (rst_n && out_valid && !out_stall) begin
      strips_seen++;
      if (strip_q.size() == 0) begin
        $display("%0t: strip with none expected, actual %p", $time, out_data);
        errors++;
      end else begin
        want = strip_q.pop_front();
        if (want != out_data) begin
          $display("%0t: strip mismatch, expected %p, actual %p", $time, want, out_data);
          errors++;
        end
      end
    end
  end

  // sender: bursts of transactions with random gaps, payload held while stalled
  int burst_left = 8;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern of its own, with one long hold-off
  int  hold_left = 0;
  int  mode = 0;
  int  mode_left = 0;
  bit  long_hold_done = 1'b0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && strips_seen >= 60) begin
      long_hold_done = 1'b1;
      hold_left = 1500;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 200);
      end
      mode_left--;
      case (mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  function automatic gdr_in_t map_item(input int x, input int y, input bit w);
    gdr_in_t t;
    t = '0;
    t.operation = OP_WRITE;
    t.column = 10'($urandom_range(0, 1023));
    t.cell_x = 6'(x);
    t.cell_y = 6'(y);
    t.cell_wall = w;
    return t;
  endfunction

  function automatic gdr_in_t cast_item(input int col);
    gdr_in_t t;
    t.operation = OP_CAST;
    t.column = 10'(col);
    t.cell_x = 6'($urandom_range(0, 63));
    t.cell_y = 6'($urandom_range(0, 63));
    t.cell_wall = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // write all six camera registers on consecutive cycles
  task automatic load_camera(input gdr_cam_t c);
    logic [15:0] vals[6];
    vals = '{{2'b00, c.player_x}, {2'b00, c.player_y}, c.dir_x, c.dir_y, c.plane_x, c.plane_y};
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_AW-1:0];
      cfg_data <= vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || strip_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // phases: defaults, zero distance, step tie, extremes, zero ray, random
  initial begin
    gdr_cam_t c;
    cam_regs = '{14'd384, 14'd384, 16'sd16384, 16'sd0, 16'sd0, 16'sd10813};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (4200) @(posedge clk);
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: c = '{14'd384, 14'd384, 16'sd16384, 16'sd0, 16'sd0, 16'sd10813};
        1: c = '{14'h0800, 14'h0880, -16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        2: c = '{14'h0880, 14'h0880, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0};
        3: c = '{14'd0, 14'd0, -16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768};
        4: c = '{14'd16383, 14'd16383, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767};
        5: c = '{14'd2000, 14'd5000, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
        default: c = '{14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
      endcase
      load_camera(c);
      case (p)
        0: begin
          pending_items.push_back(map_item(0, 0, 1'b1));
          pending_items.push_back(map_item(63, 63, 1'b1));
          pending_items.push_back(map_item(63, 0, 1'b0));
          pending_items.push_back(map_item(0, 63, 1'b1));
          pending_items.push_back(cast_item(0));
          pending_items.push_back(cast_item(639));
          pending_items.push_back(cast_item(1023));
          pending_items.push_back(cast_item(320));
          pending_items.push_back(cast_item(512));
        end
        1: begin
          // viewer on the left edge of its cell, wall right beside it
          pending_items.push_back(map_item(7, 8, 1'b1));
          pending_items.push_back(cast_item(100));
          pending_items.push_back(cast_item(600));
        end
        2: begin
          pending_items.push_back(cast_item(320));
          pending_items.push_back(cast_item(7));
        end
        default: begin
          pending_items.push_back(cast_item(0));
          pending_items.push_back(cast_item(1023));
        end
      endcase
      // random mix of map writes and casts
      for (int k = 0; k < 44; k++) begin
        if ($urandom_range(0, 99) < 35)
          pending_items.push_back(map_item($urandom_range(0, 63), $urandom_range(0, 63),
                                           $urandom_range(0, 9) < 7));
        else if ($urandom_range(0, 4) == 0)
          pending_items.push_back(cast_item($urandom_range(0, 1023)));
        else
          pending_items.push_back(cast_item($urandom_range(0, 639)));
      end
      wait_idle();
    end
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("grid_dda_raycast_column_test passed");
    end else begin
      $display("grid_dda_raycast_column_test failed");
    end
    $finish;
  end

  // limit on the whole run
  initial begin
    #60_000_000;
    $display("grid_dda_raycast_column_test failed");
    $finish;
  end

endmodule
